// ----- rtl/p4d_pkg.sv -----
package p4d_pkg;
    localparam int CoefFracBits = 14;
    localparam int TW = 42;              // transformed coordinate width
    localparam int NumW = 60;            // |t|<<17 magnitude width
    localparam int QW = 34;              // quotient bits kept (saturation check)
    localparam int SqW = 32;             // root width
    localparam int AddrW = 6;
    localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
    localparam logic [31:0] SatNeg = 32'h8000_0000;
    localparam logic [TW-1:0] ViewMin = TW'(32768);

    typedef enum logic [2:0] {
        t_reg_row0, t_reg_row1, t_reg_row2, t_reg_row3, t_reg_sxy, t_reg_szw
    } t_reg_idx;

    // one projection lane in flight through the divider
    typedef struct packed {
        logic [NumW-1:0] rem;
        logic [QW-1:0]   quo;
        logic            neg;
        logic            num_pos;
        logic            num_neg;
    } t_div_lane;

    typedef struct packed {
        logic [65:0] rem;
        logic [SqW-1:0] root;
        logic [65:0] rad;
        logic        sat;
    } t_sqrt_lane;
endpackage

// ----- rtl/p4d_core.sv -----
module p4d_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [31:0]         i_coord [4],
    input  logic [63:0]                i_rot [4],
    input  logic [63:0]                i_shift [2],
    output logic                       o_valid,
    output logic [31:0]                o_screen [3],
    output logic [31:0]                o_dist,
    output logic                       o_view
);
    import p4d_pkg::*;

    // stage counts: 1 product, 1 row sum, 1 square, 1 square sum,
    // then a radix-2 divider and a digit-by-digit root, one bit per stage
    localparam int DivSt = QW;
    localparam int SqSt = SqW;
    localparam int PreSt = 4;
    // root finishes early; its result waits here to line up with the divider
    localparam int AlignSt = DivSt - SqSt;
    localparam int Depth = PreSt + DivSt + 1;

    logic [Depth-1:0] r_vld;

    // stage 1: 16 products
    logic signed [47:0] r_prod [4][4];
    logic signed [31:0] r_sh [4];
    // stage 2: rows
    logic signed [TW-1:0] r_t [4];
    // stage 3: squares and magnitudes
    logic [63:0] r_sq [4];
    logic        r_big;
    logic signed [TW-1:0] r_t3 [4];
    // stage 4: sum of squares and divider setup
    logic [65:0] n_sum;
    t_sqrt_lane r_sq0;
    t_div_lane  r_d0 [3];
    logic [TW-1:0] r_den0;
    logic          r_wz0, r_view0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int k = 0; k < 4; k++) begin
                    r_prod[r][k] <= $signed(i_rot[r][16*k +: 16]) * i_coord[k];
                end
            end
            r_sh[0] <= $signed(i_shift[0][31:0]);
            r_sh[1] <= $signed(i_shift[0][63:32]);
            r_sh[2] <= $signed(i_shift[1][31:0]);
            r_sh[3] <= $signed(i_shift[1][63:32]);
        end
    end

    logic signed [49:0] w_acc [4];
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_acc[r] = 50'(r_prod[r][0]) + 50'(r_prod[r][1]) + 50'(r_prod[r][2])
                     + 50'(r_prod[r][3]) + 50'(1 << (CoefFracBits - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_t[r] <= TW'(w_acc[r] >>> CoefFracBits) + TW'(r_sh[r]);
            end
        end
    end

    logic [TW-1:0] w_mag [4];
    logic          w_big;
    always_comb begin
        w_big = 1'b0;
        for (int r = 0; r < 4; r++) begin
            w_mag[r] = r_t[r][TW-1] ? TW'(-r_t[r]) : TW'(r_t[r]);
            if (w_mag[r][TW-1:32] != '0) w_big = 1'b1;
        end
    end

    // a magnitude of 2^32 or more saturates anyway, so 32x32 squares suffice
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_big <= w_big;
            for (int r = 0; r < 4; r++) begin
                r_sq[r] <= 64'(w_mag[r][31:0]) * 64'(w_mag[r][31:0]);
                r_t3[r] <= r_t[r];
            end
        end
    end

    assign n_sum = 66'(r_sq[0]) + 66'(r_sq[1]) + 66'(r_sq[2]) + 66'(r_sq[3]);

    logic [TW-1:0] w_wmag;
    assign w_wmag = r_t3[3][TW-1] ? TW'(-r_t3[3]) : TW'(r_t3[3]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq0.rad  <= n_sum;
            r_sq0.rem  <= '0;
            r_sq0.root <= '0;
            r_sq0.sat  <= r_big || (n_sum[65:64] != '0);
            for (int c = 0; c < 3; c++) begin
                r_d0[c].rem <= NumW'(r_t3[c][TW-1] ? TW'(-r_t3[c]) : TW'(r_t3[c])) << 17;
                r_d0[c].quo <= '0;
                r_d0[c].neg <= r_t3[c][TW-1] ^ r_t3[3][TW-1];
                r_d0[c].num_pos <= !r_t3[c][TW-1] && (r_t3[c] != '0);
                r_d0[c].num_neg <= r_t3[c][TW-1];
            end
            r_den0  <= w_wmag;
            r_wz0   <= (r_t3[3] == '0);
            r_view0 <= (r_t3[3] >= $signed(ViewMin));
        end
    end

    // divider: restoring, quotient bits QW-1..0; numerator < 2^59, so
    // quotient bits above QW only matter as saturation, caught by a
    // high-part compare at setup of the bit stream via remainder check
    t_div_lane  r_d   [DivSt+1][3];
    logic [TW-1:0] r_den [DivSt+1];
    logic          r_wz [DivSt+1];
    logic          r_vw [DivSt+1];
    logic          r_ovf [DivSt+1][3];
    t_sqrt_lane r_s   [SqSt+1];

    always_comb begin
        r_d[0] = r_d0;
        r_den[0] = r_den0;
        r_wz[0] = r_wz0;
        r_vw[0] = r_view0;
        r_s[0] = r_sq0;
    end

    // overflow: quotient >= 2^QW iff rem >= den << QW
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            r_ovf[0][c] = ((NumW + QW)'(r_d0[c].rem) >= ((NumW + QW)'(r_den0) << QW));
        end
    end

    for (genvar g = 0; g < DivSt; g++) begin : g_div
        localparam int B = QW - 1 - g;
        logic [NumW+QW-1:0] w_trial [3];
        t_div_lane          n_lane [3];
        always_comb begin
            for (int c = 0; c < 3; c++) begin
                w_trial[c] = (NumW + QW)'(r_den[g]) << B;
                n_lane[c] = r_d[g][c];
                if ((NumW + QW)'(r_d[g][c].rem) >= w_trial[c] && r_den[g] != '0) begin
                    n_lane[c].rem = NumW'((NumW + QW)'(r_d[g][c].rem) - w_trial[c]);
                    n_lane[c].quo[B] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[g+1] <= n_lane;
                for (int c = 0; c < 3; c++) begin
                    r_ovf[g+1][c] <= r_ovf[g][c];
                end
                r_den[g+1] <= r_den[g];
                r_wz[g+1]  <= r_wz[g];
                r_vw[g+1]  <= r_vw[g];
            end
        end
    end

    // root: two radicand bits per stage, MSB pair first
    for (genvar g = 0; g < SqSt; g++) begin : g_sqrt
        logic [65:0] w_rem;
        logic [65:0] w_try;
        t_sqrt_lane  n_s;
        always_comb begin
            w_rem = {r_s[g].rem[63:0], r_s[g].rad[63 - 2*g -: 2]};
            w_try = {32'd0, r_s[g].root, 2'b01};
            n_s = r_s[g];
            if (w_rem >= w_try) begin
                n_s.rem  = w_rem - w_try;
                n_s.root = {r_s[g].root[SqW-2:0], 1'b1};
            end else begin
                n_s.rem  = w_rem;
                n_s.root = {r_s[g].root[SqW-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[g+1] <= n_s;
            end
        end
    end

    logic [31:0] w_dist;
    logic [31:0] r_dist_dly [AlignSt];
    assign w_dist = r_s[SqSt].sat ? 32'hFFFF_FFFF : r_s[SqSt].root;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist_dly[0] <= w_dist;
            for (int i = 1; i < AlignSt; i++) begin
                r_dist_dly[i] <= r_dist_dly[i-1];
            end
        end
    end

    // final saturation and sign, registered as the output stage
    logic [31:0] n_screen [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_wz[DivSt]) begin
                n_screen[c] = r_d[DivSt][c].num_pos ? SatPos :
                              (r_d[DivSt][c].num_neg ? SatNeg : 32'd0);
            end else if (r_d[DivSt][c].neg) begin
                n_screen[c] = (r_ovf[DivSt][c] || r_d[DivSt][c].quo[QW-1:31] != '0)
                              ? SatNeg : 32'(-r_d[DivSt][c].quo);
            end else begin
                n_screen[c] = (r_ovf[DivSt][c] || r_d[DivSt][c].quo[QW-1:31] != '0)
                              ? SatPos : r_d[DivSt][c].quo[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_screen <= n_screen;
            o_dist   <= r_dist_dly[AlignSt-1];
            o_view   <= r_vw[DivSt];
        end
    end

    assign o_valid = r_vld[Depth-1];

    a_sat_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_s[SqSt].sat) |=> (r_dist_dly[0] == 32'hFFFF_FFFF))
        else $error("distance saturation lost");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");
    a_wz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_wz[DivSt] && r_d[DivSt][0].num_pos) |=> (o_screen[0] == SatPos))
        else $error("zero w saturation wrong");
endmodule

// ----- rtl/point_4d_transform_project_top.sv -----
// Streaming 4D camera transform and projection. One point per cycle enters and
// one result per cycle leaves while no stall is held. Each point passes through
// matrix product, row sum, squaring and sum of squares, then the bit-per-stage
// divider (the 32-stage square root runs alongside and its result waits in
// delay registers to line up), then the output register. A stall on the result
// side freezes the entire pipeline, so o_stall follows i_stall whenever a
// result is waiting. Registers are 64-bit at byte address 8*i.
module point_4d_transform_project_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [31:0] i_coord_w,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_screen_x,
    output logic signed [31:0] o_screen_y,
    output logic signed [31:0] o_screen_z,
    output logic [31:0]        o_cam_distance,
    output logic               o_in_view
);
    import p4d_pkg::*;

    logic [63:0] r_rot [4];
    logic [63:0] r_shift [2];
    logic [2:0]  w_idx;
    logic        w_en;
    logic signed [31:0] w_coord [4];
    logic [31:0] w_screen [3];

    assign pready = 1'b1;
    assign w_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= 64'd1 << CoefFracBits;
            r_rot[1] <= (64'd1 << CoefFracBits) << 16;
            r_rot[2] <= (64'd1 << CoefFracBits) << 32;
            r_rot[3] <= (64'd1 << CoefFracBits) << 48;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                t_reg_row0: r_rot[0] <= pwdata;
                t_reg_row1: r_rot[1] <= pwdata;
                t_reg_row2: r_rot[2] <= pwdata;
                t_reg_row3: r_rot[3] <= pwdata;
                t_reg_sxy:  r_shift[0] <= pwdata;
                t_reg_szw:  r_shift[1] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            t_reg_row0: prdata = r_rot[0];
            t_reg_row1: prdata = r_rot[1];
            t_reg_row2: prdata = r_rot[2];
            t_reg_row3: prdata = r_rot[3];
            t_reg_sxy:  prdata = r_shift[0];
            t_reg_szw:  prdata = r_shift[1];
            default:    prdata = '0;
        endcase
    end

    // whole pipeline advances unless a valid result is held
    assign w_en = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_coord[0] = i_coord_x;
    assign w_coord[1] = i_coord_y;
    assign w_coord[2] = i_coord_z;
    assign w_coord[3] = i_coord_w;

    p4d_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_coord  (w_coord),
        .i_rot    (r_rot),
        .i_shift  (r_shift),
        .o_valid  (o_valid),
        .o_screen (w_screen),
        .o_dist   (o_cam_distance),
        .o_view   (o_in_view)
    );

    assign o_screen_x = w_screen[0];
    assign o_screen_y = w_screen[1];
    assign o_screen_z = w_screen[2];
endmodule
